FILE: rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rgbhsv_pkg;

    // Default component width of the input pixel.
    localparam int DefComponentBits = 8;

    // Result field widths.
    localparam int HueBits    = 13;
    localparam int SatBits    = 8;
    localparam int BrightBits = 8;
    localparam int OutDataW   = ((HueBits + SatBits + BrightBits + 7) / 8) * 8;

    // Saturation full scale and hue geometry in sixteenths of a degree.
    localparam int SatFull       = 255;
    localparam int HueSector     = 1920;
    localparam int HueHalfSector = 960;
    localparam int HueFull       = 5760;

    // Quotient widths: saturation stays below 256, the hue term below 1024.
    localparam int SatQBits = 8;
    localparam int HueQBits = 10;

    // Which component holds the maximum.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

`default_nettype wire

FILE: rtl/rgb_to_hsv_converter_unit.sv
// Pipelined RGB to HSV converter with bit-per-stage dividers.
//
//  Port group   Direction  Payload
//  s_ (input)   in         tdata: red, green, blue (COMPONENT_BITS each)
//  m_ (result)  out        tdata: hue, saturation, brightness; tuser: hue_undefined
//
// One word is taken every cycle while m_tready does not stall the output; the pipeline
// depth is set by the restoring dividers, which settle one quotient bit per stage.
// Reset (aresetn low, synchronous) clears the valid bits only; payload is not reset.
// A stall on m_tready freezes the whole pipeline; s_tready stays high while the
// output register is empty or being taken.
`default_nettype none

module rgb_to_hsv_converter_unit #(
    parameter int COMPONENT_BITS = rgbhsv_pkg::DefComponentBits
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    // tdata: red, green, blue from the lowest bit up, zero padded to bytes
    input  wire  [((3*COMPONENT_BITS+7)/8)*8-1:0]      s_tdata,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // tdata: hue, saturation, brightness from the lowest bit up, zero padded
    output logic [rgbhsv_pkg::OutDataW-1:0]            m_tdata,
    // tuser: hue_undefined
    output logic                                       m_tuser,
    output logic                                       m_tvalid,
    input  wire                                        m_tready
);

    localparam int CB      = COMPONENT_BITS;
    localparam int SatNumW = CB + rgbhsv_pkg::SatQBits;
    localparam int HueNumW = CB + rgbhsv_pkg::HueQBits;
    localparam int Steps   = rgbhsv_pkg::HueQBits;
    localparam int HB      = rgbhsv_pkg::HueBits;
    localparam int PadW    = rgbhsv_pkg::OutDataW - HB - rgbhsv_pkg::SatBits
                             - rgbhsv_pkg::BrightBits;

    logic en;

    // ------------------------------------------------------------------
    // Stage 1: maximum, minimum, delta and the signed difference.
    // ------------------------------------------------------------------
    logic [CB-1:0]         red, green, blue;
    logic [CB-1:0]         mx_next, mn_next, adiff_next;
    logic                  neg_next;
    rgbhsv_pkg::sector_t   sect_next;

    logic                  v1_reg;
    logic [CB-1:0]         mx1_reg, delta1_reg, adiff1_reg;
    logic                  neg1_reg, undef1_reg;
    rgbhsv_pkg::sector_t   sect1_reg;

    assign red   = s_tdata[CB-1:0];
    assign green = s_tdata[2*CB-1:CB];
    assign blue  = s_tdata[3*CB-1:2*CB];

    always_comb begin
        mx_next = red;
        mn_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next)  mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next)  mn_next = blue;
        // Red wins ties over green, and green over blue.
        if (red == mx_next) begin
            sect_next  = rgbhsv_pkg::SECT_RED;
            neg_next   = green < blue;
            adiff_next = neg_next ? blue - green : green - blue;
        end else if (green == mx_next) begin
            sect_next  = rgbhsv_pkg::SECT_GREEN;
            neg_next   = blue < red;
            adiff_next = neg_next ? red - blue : blue - red;
        end else begin
            sect_next  = rgbhsv_pkg::SECT_BLUE;
            neg_next   = red < green;
            adiff_next = neg_next ? green - red : red - green;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            mx1_reg    <= mx_next;
            delta1_reg <= mx_next - mn_next;
            adiff1_reg <= adiff_next;
            neg1_reg   <= neg_next;
            sect1_reg  <= sect_next;
            undef1_reg <= (mx_next == mn_next);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dividend scaling by shift and subtract, then the divider.
    // ------------------------------------------------------------------
    logic                  dv_reg     [0:Steps];
    logic [HueNumW-1:0]    hrem_reg   [0:Steps];
    logic [CB-1:0]         hdiv_reg   [0:Steps];
    logic [Steps-1:0]      hq_reg     [0:Steps];
    logic [SatNumW-1:0]    srem_reg   [0:Steps];
    logic [CB-1:0]         sdiv_reg   [0:Steps];
    logic [rgbhsv_pkg::SatQBits-1:0] sq_reg [0:Steps];
    logic                  neg_reg    [0:Steps];
    logic                  undef_reg  [0:Steps];
    rgbhsv_pkg::sector_t   sect_reg   [0:Steps];
    logic [CB-1:0]         bright_reg [0:Steps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v1_reg;
        end
        if (en) begin
            // 960 * x = 1024 * x - 64 * x, 255 * x = 256 * x - x.
            hrem_reg[0]   <= (HueNumW'(adiff1_reg) << 10) - (HueNumW'(adiff1_reg) << 6);
            srem_reg[0]   <= (SatNumW'(delta1_reg) << 8) - SatNumW'(delta1_reg);
            hdiv_reg[0]   <= delta1_reg;
            sdiv_reg[0]   <= mx1_reg;
            hq_reg[0]     <= '0;
            sq_reg[0]     <= '0;
            neg_reg[0]    <= neg1_reg;
            undef_reg[0]  <= undef1_reg;
            sect_reg[0]   <= sect1_reg;
            bright_reg[0] <= mx1_reg;
        end
    end

    // One quotient bit per stage, most significant first. The saturation
    // quotient is two bits narrower and joins two stages later.
    for (genvar k = 0; k < Steps; k++) begin : g_div
        localparam int QB = Steps - 1 - k;

        logic [HueNumW-1:0]    hsub;
        logic                  hge;
        logic [HueNumW-1:0]    hrem_next;
        logic [Steps-1:0]      hq_next;
        logic [SatNumW-1:0]    srem_next;
        logic [rgbhsv_pkg::SatQBits-1:0] sq_next;

        always_comb begin
            hsub      = HueNumW'(hdiv_reg[k]) << QB;
            hge       = hrem_reg[k] >= hsub;
            hrem_next = hge ? hrem_reg[k] - hsub : hrem_reg[k];
            hq_next   = hq_reg[k];
            hq_next[QB] = hge;
        end

        if (QB < rgbhsv_pkg::SatQBits) begin : g_sat
            logic [SatNumW-1:0] ssub;
            logic               sge;
            always_comb begin
                ssub      = SatNumW'(sdiv_reg[k]) << QB;
                sge       = srem_reg[k] >= ssub;
                srem_next = sge ? srem_reg[k] - ssub : srem_reg[k];
                sq_next   = sq_reg[k];
                sq_next[QB] = sge;
            end
        end else begin : g_sat_wait
            always_comb begin
                srem_next = srem_reg[k];
                sq_next   = sq_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
            if (en) begin
                hrem_reg[k+1]   <= hrem_next;
                hq_reg[k+1]     <= hq_next;
                srem_reg[k+1]   <= srem_next;
                sq_reg[k+1]     <= sq_next;
                hdiv_reg[k+1]   <= hdiv_reg[k];
                sdiv_reg[k+1]   <= sdiv_reg[k];
                neg_reg[k+1]    <= neg_reg[k];
                undef_reg[k+1]  <= undef_reg[k];
                sect_reg[k+1]   <= sect_reg[k];
                bright_reg[k+1] <= bright_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: sector offset, sign and wrap, into the output register.
    // ------------------------------------------------------------------
    logic [HB-1:0]  offset;
    logic [HB:0]    hue_sum;
    logic [HB-1:0]  hue_next;

    logic                            m_tvalid_reg;
    logic [HB-1:0]                   hue_reg;
    logic [rgbhsv_pkg::SatBits-1:0]  sat_reg;
    logic [rgbhsv_pkg::BrightBits-1:0] bright_out_reg;
    logic                            undef_out_reg;

    always_comb begin
        case (sect_reg[Steps])
            rgbhsv_pkg::SECT_RED:   offset = '0;
            rgbhsv_pkg::SECT_GREEN: offset = HB'(rgbhsv_pkg::HueSector);
            rgbhsv_pkg::SECT_BLUE:  offset = HB'(2 * rgbhsv_pkg::HueSector);
            default:                offset = '0;
        endcase
        if (neg_reg[Steps]) begin
            hue_sum = (HB+1)'(offset) - (HB+1)'(hq_reg[Steps]);
        end else begin
            hue_sum = (HB+1)'(offset) + (HB+1)'(hq_reg[Steps]);
        end
        // A negative angle only arises in the red sector and wraps once.
        if (hue_sum[HB]) begin
            hue_sum = hue_sum + (HB+1)'(rgbhsv_pkg::HueFull);
        end
        hue_next = undef_reg[Steps] ? '0 : hue_sum[HB-1:0];
    end

    assign en = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_reg[Steps];
        end
        if (en) begin
            hue_reg        <= hue_next;
            sat_reg        <= undef_reg[Steps] ? '0 : sq_reg[Steps];
            bright_out_reg <= rgbhsv_pkg::BrightBits'(bright_reg[Steps]);
            undef_out_reg  <= undef_reg[Steps];
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = undef_out_reg;
    assign m_tdata  = {{PadW{1'b0}}, bright_out_reg, sat_reg, hue_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && undef_out_reg |-> hue_reg == '0 && sat_reg == '0)
        else $error("undefined hue word carries nonzero hue or saturation");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> hue_reg < HB'(rgbhsv_pkg::HueFull))
        else $error("hue beyond full circle");

    a_sat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !undef_out_reg |-> sat_reg != '0)
        else $error("coloured pixel produced zero saturation");

    a_hue_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[Steps] && !undef_reg[Steps]
            |-> hq_reg[Steps] <= Steps'(rgbhsv_pkg::HueHalfSector))
        else $error("hue quotient exceeds half sector");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word did not enter the pipeline");

endmodule

`default_nettype wire
